// ----- hdl/frx_pkg.sv -----
// ----------------------------------------------------------------------------
// frx_pkg
// Shared constants and codes for the length-and-XOR frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

  // Frame buffer geometry.
  localparam int unsigned BufBytes = 1024;
  localparam int unsigned AddrW    = $clog2(BufBytes);
  // Byte counter and length width; must hold the buffer size itself.
  localparam int unsigned LenW     = 11;

  // Frame layout: start, command, four length bytes, payload, check, end.
  localparam int unsigned HdrBytes = 6;
  localparam int unsigned MinCap   = 10;

  // Item field widths.
  localparam int unsigned OpW   = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TimeW = 32;
  localparam int unsigned TmoW  = 16;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgStartChar = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndChar   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxLen    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd3;

  // Item operations.
  localparam logic [OpW-1:0] OpRecv    = 2'd0;
  localparam logic [OpW-1:0] OpRelease = 2'd1;
  localparam logic [OpW-1:0] OpRead    = 2'd2;

  // Receiver phases, also reported as status.
  localparam logic [1:0] PhIdle     = 2'd0;
  localparam logic [1:0] PhHeader   = 2'd1;
  localparam logic [1:0] PhPayload  = 2'd2;
  localparam logic [1:0] PhComplete = 2'd3;

endpackage

// ----- hdl/frx_if.sv -----
// ----------------------------------------------------------------------------
// frx_in_if / frx_out_if
// Valid/ready channels for receiver items and their results.
// ----------------------------------------------------------------------------
interface frx_in_if import frx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [ByteW-1:0]  rx_byte;
  logic [TimeW-1:0]  now_ms;
  logic [AddrW-1:0]  read_index;

  modport source (output valid, opcode, rx_byte, now_ms, read_index, input ready);
  modport sink   (input valid, opcode, rx_byte, now_ms, read_index, output ready);
endinterface

interface frx_out_if import frx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              frame_done;
  logic [ByteW-1:0]  command;
  logic [LenW-1:0]   payload_len;
  logic [ByteW-1:0]  read_data;

  modport source (output valid, status, frame_done, command, payload_len, read_data,
                  input ready);
  modport sink   (input valid, status, frame_done, command, payload_len, read_data,
                  output ready);
endinterface

// ----- hdl/frame_receiver_xor_len.sv -----
// ----------------------------------------------------------------------------
// frame_receiver_xor_len
// Byte-serial frame receiver with a little-endian length field and XOR check.
// ----------------------------------------------------------------------------
// Each item is handled as it is accepted, and the block accepts one item per clock
// while the result side keeps up; every item yields exactly one result, in the
// cycle after acceptance, through a single output register. Received bytes are
// written into a 1024-byte single-port-style buffer memory, and read items get
// their byte from that memory's registered read port. Header fields, the
// running XOR and the check byte are held in registers so no buffer read is
// needed on the receive path. A read item returns the buffer byte at its index
// whether or not that position has been written.
// ----------------------------------------------------------------------------
module frame_receiver_xor_len import frx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  frx_in_if.sink              in_i,
  frx_out_if.source           out_o
);

  // Configuration registers.
  logic [ByteW-1:0] start_char_q, end_char_q;
  logic [LenW-1:0]  max_len_q;
  logic [TmoW-1:0]  timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= '0;
      end_char_q   <= '0;
      max_len_q    <= LenW'(BufBytes);
      timeout_q    <= TmoW'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartChar: start_char_q <= cfg_data_i[ByteW-1:0];
        CfgEndChar:   end_char_q   <= cfg_data_i[ByteW-1:0];
        CfgMaxLen:    max_len_q    <= cfg_data_i[LenW-1:0];
        CfgTimeout:   timeout_q    <= cfg_data_i[TmoW-1:0];
        default:      ;
      endcase
    end
  end

  // Receiver state.
  logic [1:0]       phase_q, phase_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  flen_q, flen_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [23:0]      lenb_q, lenb_d;
  logic [ByteW-1:0] chk_q, chk_d;

  // Output stage.
  logic             out_v_q;
  logic [1:0]       out_status_q;
  logic             out_done_q;
  logic [ByteW-1:0] out_cmd_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_rd_q;
  logic [ByteW-1:0] rd_q;

  logic in_fire;
  assign in_i.ready = !out_v_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Gap since the previous byte; a wrapped stamp counts one less.
  logic [TimeW-1:0] gap;
  logic             timed_out;
  assign gap       = in_i.now_ms - last_q - TimeW'(in_i.now_ms < last_q);
  assign timed_out = gap > TimeW'(timeout_q);

  // Length check against the usable buffer size.
  logic [LenW-1:0] cap;
  logic [31:0]     len_word;
  logic            len_ok;
  assign cap      = (max_len_q > LenW'(BufBytes)) ? LenW'(BufBytes) : max_len_q;
  assign len_word = {in_i.rx_byte, lenb_q};
  assign len_ok   = (cap >= LenW'(MinCap)) &&
                    (len_word <= 32'(cap - LenW'(MinCap)));

  logic [1:0]       eff_phase;
  logic             done;
  logic             we;
  logic [LenW-1:0]  wpos;
  logic             rd_en;
  logic [LenW-1:0]  chk_pos, end_pos;
  logic             have_hdr;

  assign eff_phase = (timed_out && phase_q != PhComplete) ? PhIdle : phase_q;
  assign chk_pos   = flen_q + LenW'(HdrBytes);
  assign end_pos   = chk_pos + LenW'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    flen_d  = flen_q;
    last_d  = last_q;
    xor_d   = xor_q;
    cmd_d   = cmd_q;
    lenb_d  = lenb_q;
    chk_d   = chk_q;
    done    = 1'b0;
    we      = 1'b0;
    wpos    = cnt_q;
    rd_en   = 1'b0;
    unique case (in_i.opcode)
      OpRecv: begin
        last_d  = in_i.now_ms;
        // A late byte drops a partial frame even when it does not restart one.
        phase_d = eff_phase;
        unique case (eff_phase)
          PhIdle: begin
            if (in_i.rx_byte == start_char_q) begin
              phase_d = PhHeader;
              cnt_d   = LenW'(1);
              xor_d   = '0;
              we      = 1'b1;
              wpos    = '0;
            end
          end
          PhHeader: begin
            we    = 1'b1;
            xor_d = xor_q ^ in_i.rx_byte;
            cnt_d = cnt_q + LenW'(1);
            case (cnt_q)
              LenW'(1): cmd_d          = in_i.rx_byte;
              LenW'(2): lenb_d[7:0]    = in_i.rx_byte;
              LenW'(3): lenb_d[15:8]   = in_i.rx_byte;
              LenW'(4): lenb_d[23:16]  = in_i.rx_byte;
              default: begin
                // Last length byte: accept or drop the frame.
                if (len_ok) begin
                  phase_d = PhPayload;
                  flen_d  = len_word[LenW-1:0];
                end else begin
                  phase_d = PhIdle;
                end
              end
            endcase
          end
          PhPayload: begin
            we    = 1'b1;
            cnt_d = cnt_q + LenW'(1);
            if (cnt_q < chk_pos) begin
              xor_d = xor_q ^ in_i.rx_byte;
            end
            if (cnt_q == chk_pos) begin
              chk_d = in_i.rx_byte;
            end
            if (cnt_q == end_pos) begin
              if (chk_q == xor_q && in_i.rx_byte == end_char_q) begin
                phase_d = PhComplete;
                done    = 1'b1;
              end else begin
                phase_d = PhIdle;
              end
            end
          end
          default: ;
        endcase
      end
      OpRelease: phase_d = PhIdle;
      OpRead:    rd_en   = ({1'b0, in_i.read_index} < LenW'(BufBytes));
      default:   ;
    endcase
  end

  assign have_hdr = (phase_d == PhPayload) || (phase_d == PhComplete);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      flen_q  <= '0;
      last_q  <= '0;
      xor_q   <= '0;
      cmd_q   <= '0;
      lenb_q  <= '0;
      chk_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flen_q  <= flen_d;
      last_q  <= last_d;
      xor_q   <= xor_d;
      cmd_q   <= cmd_d;
      lenb_q  <= lenb_d;
      chk_q   <= chk_d;
    end
  end

  // Frame buffer with a registered read port.
  logic [ByteW-1:0] mem [BufBytes];

  always_ff @(posedge clk_i) begin
    if (in_fire && we && (wpos < LenW'(BufBytes))) begin
      mem[wpos[AddrW-1:0]] <= in_i.rx_byte;
    end
    if (in_fire && rd_en) begin
      rd_q <= mem[in_i.read_index];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (in_fire) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_status_q <= phase_d;
      out_done_q   <= done;
      out_cmd_q    <= have_hdr ? cmd_d : '0;
      out_len_q    <= have_hdr ? flen_d : '0;
      out_rd_q     <= rd_en;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.status      = out_status_q;
  assign out_o.frame_done  = out_done_q;
  assign out_o.command     = out_cmd_q;
  assign out_o.payload_len = out_len_q;
  assign out_o.read_data   = out_rd_q ? rd_q : '0;

  // A completed frame is always reported together with the complete status.
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_done_q |-> out_status_q == PhComplete)
    else $error("frame_done without complete status");

  // The header count only spans the command and length bytes.
  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHeader |-> cnt_q >= LenW'(1) && cnt_q <= LenW'(5))
    else $error("header byte count out of range");

  // The payload count never passes the end byte of the declared frame.
  a_pay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> cnt_q >= LenW'(HdrBytes) && cnt_q <= end_pos)
    else $error("payload byte count past end of frame");

  // Every accepted item leaves a result in the output register.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_v_q)
    else $error("accepted item produced no result");

endmodule
